// ===== hdl/ffp_pkg.sv =====
package ffp_pkg;

  // Field widths of the request and response channels
  localparam int unsigned REQ_X_W    = 10;
  localparam int unsigned RECT_W_W   = 11;
  localparam int unsigned RECT_H_W   = 7;
  localparam int unsigned OFF_X_W    = 10;
  localparam int unsigned OFF_Y_W    = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BOUND_W_W  = 11;
  localparam int unsigned BOUND_H_W  = 7;

  localparam logic [BOUND_W_W-1:0] BOUND_W_MAX = '1;
  localparam logic [BOUND_H_W-1:0] BOUND_H_MAX = '1;

  // Request opcodes
  localparam logic CMD_PREPLACE = 1'b0;
  localparam logic CMD_PLACE    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_PLACED  = 2'd0,
    STATUS_NO_FIT  = 2'd1,
    STATUS_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_MARK,
    S_DONE
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic    clear;
    logic    load;
    logic    start_search;
    logic    start_mark;
    logic    search;
    logic    mark;
    logic    grow;
    logic    set_code;
    status_e code;
    logic    out_load;
  } ffp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_place;
    logic bound_fail;
    logic w_zero;
    logic hit;
    logic exhausted;
    logic mark_done;
    logic clear_last;
  } ffp_stat_t;

endpackage

// ===== hdl/ffp_datapath.sv =====
module ffp_datapath import ffp_pkg::*; #(
  parameter int unsigned GRID_COLUMNS = 1024,
  parameter int unsigned GRID_ROWS    = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffp_cmd_t             ctl_i,
  output ffp_stat_t            stat_o,
  input  logic                 cmd_i,
  input  logic [REQ_X_W-1:0]   req_x_i,
  input  logic [RECT_W_W-1:0]  rect_width_i,
  input  logic [RECT_H_W-1:0]  rect_height_i,
  input  logic [OFF_X_W-1:0]   off_x_i,
  input  logic [OFF_Y_W-1:0]   off_y_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [REQ_X_W-1:0]   placed_x_o,
  output logic [BOUND_W_W-1:0] bound_width_o,
  output logic [BOUND_H_W-1:0] bound_height_o
);

  localparam int unsigned CW = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int unsigned NW = $clog2(GRID_COLUMNS + 1);
  localparam int unsigned SW = ((NW > 12) ? NW : 12) + 1;
  localparam int unsigned PW = (NW > REQ_X_W) ? NW : REQ_X_W;
  localparam int unsigned YW = RECT_H_W + 1;

  localparam logic [SW-1:0] GC_S   = SW'(GRID_COLUMNS);
  localparam logic [YW-1:0] GR_S   = YW'(GRID_ROWS);
  localparam logic [NW-1:0] LAST_N = NW'(GRID_COLUMNS - 1);
  localparam logic [CW-1:0] LAST_C = CW'(GRID_COLUMNS - 1);

  // Column mask memory
  logic [GRID_ROWS-1:0] occ_mem_q [GRID_COLUMNS];
  logic [GRID_ROWS-1:0] rdata_q;

  // Request registers
  logic                cmd_q;
  logic [REQ_X_W-1:0]  rx_q;
  logic [RECT_W_W-1:0] w_q;
  logic [RECT_H_W-1:0] h_q;
  logic [OFF_X_W-1:0]  ox_q;
  logic [OFF_Y_W-1:0]  oy_q;

  logic [NW-1:0]        iss_q, iss_d;
  logic                 v_q, v_d;
  logic [CW-1:0]        col_q;
  logic [RECT_W_W-1:0]  run_q, run_d;
  logic [RECT_W_W-1:0]  left_q, left_d;
  logic [PW-1:0]        px_q;
  status_e              code_q;
  logic [BOUND_W_W-1:0] ext_w_q, ext_w_d;
  logic [BOUND_H_W-1:0] ext_h_q, ext_h_d;

  logic [STATUS_W-1:0]  status_q;
  logic [REQ_X_W-1:0]   placed_x_q;
  logic [BOUND_W_W-1:0] bound_w_q;
  logic [BOUND_H_W-1:0] bound_h_q;

  logic [GRID_ROWS-1:0] mask;
  logic [YW-1:0]        yend;
  logic [SW-1:0]        span_s, pre_end_s, hit_start_s, hit_px_s;
  logic [SW-1:0]        go_px_s, go_start_s, xend_s;
  logic [BOUND_W_W-1:0] xend_sat;
  logic [BOUND_H_W-1:0] yend_sat;
  logic [RECT_W_W-1:0]  run_inc;
  logic                 free, hit, exhausted, bound_fail, issue;
  logic                 we;
  logic [CW-1:0]        wa;
  logic [GRID_ROWS-1:0] wd;

  always_comb begin
    for (int r = 0; r < GRID_ROWS; r++) begin
      mask[r] = (YW'(r) >= YW'(oy_q)) && (YW'(r) < yend);
    end
  end

  assign yend      = YW'(oy_q) + YW'(h_q);
  assign span_s    = SW'(ox_q) + SW'(w_q);
  assign pre_end_s = span_s + SW'(rx_q);

  assign bound_fail = (cmd_q == CMD_PLACE) ? ((span_s > GC_S) || (yend > GR_S))
                                           : ((pre_end_s > GC_S) || (yend > GR_S));

  // Search evaluation on the column read in the previous cycle
  assign free      = ~|(rdata_q & mask);
  assign run_inc   = run_q + RECT_W_W'(1);
  assign hit       = ctl_i.search && v_q && free && (run_inc == w_q);
  assign exhausted = ctl_i.search && v_q && !hit && (col_q == LAST_C);

  assign hit_start_s = SW'(col_q) + SW'(1) - SW'(w_q);
  assign hit_px_s    = hit_start_s - SW'(ox_q);
  assign go_px_s     = (cmd_q == CMD_PLACE) ? '0 : SW'(rx_q);
  assign go_start_s  = go_px_s + SW'(ox_q);

  assign xend_s   = SW'(px_q) + span_s;
  assign xend_sat = (xend_s > SW'(BOUND_W_MAX)) ? BOUND_W_MAX : xend_s[BOUND_W_W-1:0];
  assign yend_sat = (yend > YW'(BOUND_H_MAX)) ? BOUND_H_MAX : yend[BOUND_H_W-1:0];

  assign issue = (ctl_i.search && !hit && (iss_q <= LAST_N)) ||
                 (ctl_i.mark && (left_q != '0));

  // Write port: zero sweep after reset, otherwise read-modify-write of a marked column
  assign we = ctl_i.clear || (ctl_i.mark && v_q);
  assign wa = ctl_i.clear ? iss_q[CW-1:0] : col_q;
  assign wd = ctl_i.clear ? '0 : (rdata_q | mask);

  always_ff @(posedge clk_i) begin
    if (we) begin
      occ_mem_q[wa] <= wd;
    end
    if (issue) begin
      rdata_q <= occ_mem_q[iss_q[CW-1:0]];
    end
  end

  always_comb begin
    iss_d   = iss_q;
    run_d   = run_q;
    left_d  = left_q;
    v_d     = issue;
    ext_w_d = ext_w_q;
    ext_h_d = ext_h_q;
    if (ctl_i.clear) begin
      iss_d = iss_q + NW'(1);
    end
    if (ctl_i.start_search) begin
      iss_d = NW'(ox_q);
      run_d = '0;
    end
    if (ctl_i.start_mark) begin
      iss_d  = NW'(go_start_s);
      left_d = w_q;
    end
    if (ctl_i.search) begin
      if (hit) begin
        iss_d  = NW'(hit_start_s);
        left_d = w_q;
      end else begin
        if (issue) begin
          iss_d = iss_q + NW'(1);
        end
        if (v_q) begin
          run_d = free ? run_inc : '0;
        end
      end
    end
    if (ctl_i.mark && issue) begin
      iss_d  = iss_q + NW'(1);
      left_d = left_q - RECT_W_W'(1);
    end
    if (ctl_i.grow) begin
      if (xend_sat > ext_w_q) begin
        ext_w_d = xend_sat;
      end
      if (yend_sat > ext_h_q) begin
        ext_h_d = yend_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q   <= '0;
      v_q     <= 1'b0;
      run_q   <= '0;
      left_q  <= '0;
      ext_w_q <= '0;
      ext_h_q <= '0;
    end else begin
      iss_q   <= iss_d;
      v_q     <= v_d;
      run_q   <= run_d;
      left_q  <= left_d;
      ext_w_q <= ext_w_d;
      ext_h_q <= ext_h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      rx_q   <= req_x_i;
      w_q    <= rect_width_i;
      h_q    <= rect_height_i;
      ox_q   <= off_x_i;
      oy_q   <= off_y_i;
      px_q   <= '0;
      code_q <= STATUS_PLACED;
    end
    if (ctl_i.set_code) begin
      code_q <= ctl_i.code;
    end
    if (ctl_i.start_mark) begin
      px_q <= PW'(go_px_s);
    end
    if (hit) begin
      px_q <= PW'(hit_px_s);
    end
    if (issue) begin
      col_q <= iss_q[CW-1:0];
    end
    if (ctl_i.out_load) begin
      status_q   <= code_q;
      placed_x_q <= px_q[REQ_X_W-1:0];
      bound_w_q  <= ext_w_q;
      bound_h_q  <= ext_h_q;
    end
  end

  assign stat_o.is_place   = (cmd_q == CMD_PLACE);
  assign stat_o.bound_fail = bound_fail;
  assign stat_o.w_zero     = (w_q == '0);
  assign stat_o.hit        = hit;
  assign stat_o.exhausted  = exhausted;
  assign stat_o.mark_done  = (left_q == '0) && !v_q;
  assign stat_o.clear_last = (iss_q == LAST_N);

  assign status_o       = status_q;
  assign placed_x_o     = placed_x_q;
  assign bound_width_o  = bound_w_q;
  assign bound_height_o = bound_h_q;

endmodule

// ===== hdl/ffp_ctrl.sv =====
module ffp_ctrl import ffp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ffp_cmd_t  ctl_o,
  input  ffp_stat_t stat_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.bound_fail) begin
          state_d = S_DONE;
        end else if (stat_i.is_place && !stat_i.w_zero) begin
          state_d = S_SEARCH;
        end else begin
          state_d = S_MARK;
        end
      end
      S_SEARCH: begin
        if (stat_i.hit) begin
          state_d = S_MARK;
        end else if (stat_i.exhausted) begin
          state_d = S_DONE;
        end
      end
      S_MARK: begin
        if (stat_i.mark_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    ctl_o.code = STATUS_PLACED;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clear = 1'b1;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        ctl_o.load = in_valid_i;
      end
      S_CHECK: begin
        if (stat_i.bound_fail) begin
          ctl_o.set_code = 1'b1;
          ctl_o.code     = stat_i.is_place ? STATUS_NO_FIT : STATUS_OUTSIDE;
        end else if (stat_i.is_place && !stat_i.w_zero) begin
          ctl_o.start_search = 1'b1;
        end else begin
          ctl_o.start_mark = 1'b1;
        end
      end
      S_SEARCH: begin
        ctl_o.search = 1'b1;
        if (stat_i.exhausted) begin
          ctl_o.set_code = 1'b1;
          ctl_o.code     = STATUS_NO_FIT;
        end
      end
      S_MARK: begin
        ctl_o.mark = 1'b1;
        ctl_o.grow = stat_i.mark_done;
      end
      S_DONE: begin
        ctl_o.out_load = out_free;
      end
      default: begin
        ctl_o.clear = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/first_fit_tile_placer.sv =====
// Channel   Handshake                Payload
// request   in_valid_i / in_stall_o  cmd_i req_x_i rect_width_i rect_height_i off_x_i off_y_i
// response  out_valid_o/out_stall_i  status_o placed_x_o bound_width_o bound_height_o
//
// After reset a sweep zeroes the column mask memory, one column per cycle, so the
// request channel stalls until the sweep is done. One request is worked at a time.
// A preplace marks rect_width columns from req_x + off_x; a place scans column masks
// one per cycle from off_x, then marks rect_width columns. The mask memory has a
// single read port and a single write port. A finished result sits in the output
// register while the next request is taken; a stalled response only holds the next
// result back.
module first_fit_tile_placer import ffp_pkg::*; #(
  parameter int unsigned GRID_COLUMNS = 1024,
  parameter int unsigned GRID_ROWS    = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [REQ_X_W-1:0]   req_x_i,
  input  logic [RECT_W_W-1:0]  rect_width_i,
  input  logic [RECT_H_W-1:0]  rect_height_i,
  input  logic [OFF_X_W-1:0]   off_x_i,
  input  logic [OFF_Y_W-1:0]   off_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [REQ_X_W-1:0]   placed_x_o,
  output logic [BOUND_W_W-1:0] bound_width_o,
  output logic [BOUND_H_W-1:0] bound_height_o
);

  ffp_cmd_t  ctl;
  ffp_stat_t stat;

  // Sequence the clear sweep after reset, then per request: bounds check, search, mark, respond
  ffp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .stat_i      (stat)
  );

  // Hold the mask memory, the request, the extents and the response register
  ffp_datapath #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .req_x_i        (req_x_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .off_x_i        (off_x_i),
    .off_y_i        (off_y_i),
    .status_o       (status_o),
    .placed_x_o     (placed_x_o),
    .bound_width_o  (bound_width_o),
    .bound_height_o (bound_height_o)
  );

endmodule
